FILE: rtl/core/mtne_pkg.sv
package mtne_pkg;

	localparam int MAX_BINS = 513;
	localparam int IDX_W    = 10;
	localparam int PWR_W    = 40;
	localparam int ADDR_W   = $clog2(MAX_BINS);
	localparam int WSUM_W   = PWR_W + 2;
	localparam int BETA_W   = 17;
	localparam int FRM_W    = 15;
	localparam int FSW_W    = 9;

	localparam logic [FRM_W-1:0]  FRAMES_CAP = 15'd20000;
	localparam logic [BETA_W-1:0] BETA_ONE   = 17'd65536;
	localparam logic [BETA_W-1:0] BETA_FLOOR = 17'd1966;
	localparam logic [PWR_W-1:0]  NOISE_INIT = 40'd256;

	localparam logic [IDX_W-1:0] BINS_RESET = 10'd257;
	localparam logic [IDX_W-1:0] BINS_MIN   = 10'd3;
	localparam logic [IDX_W-1:0] BINS_MAX   = IDX_W'(MAX_BINS);

	// x = 16*S + wsum + 10, divided by 20 as (x >> 2) / 5 in two chunks
	localparam int X_W    = PWR_W + 5;
	localparam int DIV_LO = 22;
	localparam int YH_W   = X_W - 2 - DIV_LO;
	localparam int QH_W   = YH_W - 2;
	localparam int Z_W    = 3 + DIV_LO;
	localparam int M_W    = 25;
	localparam int DIV_SH = 27;
	localparam logic [M_W-1:0] DIV5_M = 25'd26843546;
	localparam int QH_PW  = YH_W + M_W;
	localparam int QL_PW  = Z_W + M_W;

	localparam int NP_W   = BETA_W + PWR_W;
	localparam int NSUM_W = NP_W + 1;
	localparam logic [NSUM_W-1:0] NZ_ROUND = NSUM_W'(32768);

	// configuration port
	localparam int CFG_AW = 3;
	localparam int CFG_DW = 32;
	localparam logic [CFG_AW-3:0] REG_BINS_PER_FRAME = '0;

	// result queue
	localparam int OQ_DEPTH = 8;
	localparam int OQ_AW    = $clog2(OQ_DEPTH);
	localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

	localparam int OUT_TDATA_W = 96;
	localparam int OUT_PAD_W   = OUT_TDATA_W - IDX_W - 2 * PWR_W;

	typedef struct packed {
		logic [PWR_W-1:0] smooth;
		logic [PWR_W-1:0] rmin;
		logic [PWR_W-1:0] wmin;
		logic [PWR_W-1:0] noise;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);
	localparam entry_t ENTRY_INIT = '{smooth: '0, rmin: '0, wmin: '0, noise: NOISE_INIT};

	typedef struct packed {
		logic [IDX_W-1:0]  k;
		logic [WSUM_W-1:0] wsum;
		logic [PWR_W-1:0]  pw;
		logic              last;
		logic              first;
		logic              restart;
		logic [BETA_W-1:0] beta;
	} op_t;

	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic [PWR_W-1:0] smooth;
		logic [PWR_W-1:0] noise;
		logic             upd;
		logic             last;
	} res_t;

	// round(65536 / n), floored at 0.03
	function automatic logic [BETA_W-1:0] beta_lookup(input logic [FRM_W-1:0] n);
		case (n)
			15'd0, 15'd1: beta_lookup = BETA_ONE;
			15'd2:  beta_lookup = 17'd32768;
			15'd3:  beta_lookup = 17'd21845;
			15'd4:  beta_lookup = 17'd16384;
			15'd5:  beta_lookup = 17'd13107;
			15'd6:  beta_lookup = 17'd10923;
			15'd7:  beta_lookup = 17'd9362;
			15'd8:  beta_lookup = 17'd8192;
			15'd9:  beta_lookup = 17'd7282;
			15'd10: beta_lookup = 17'd6554;
			15'd11: beta_lookup = 17'd5958;
			15'd12: beta_lookup = 17'd5461;
			15'd13: beta_lookup = 17'd5041;
			15'd14: beta_lookup = 17'd4681;
			15'd15: beta_lookup = 17'd4369;
			15'd16: beta_lookup = 17'd4096;
			15'd17: beta_lookup = 17'd3855;
			15'd18: beta_lookup = 17'd3641;
			15'd19: beta_lookup = 17'd3449;
			15'd20: beta_lookup = 17'd3277;
			15'd21: beta_lookup = 17'd3121;
			15'd22: beta_lookup = 17'd2979;
			15'd23: beta_lookup = 17'd2849;
			15'd24: beta_lookup = 17'd2731;
			15'd25: beta_lookup = 17'd2621;
			15'd26: beta_lookup = 17'd2521;
			15'd27: beta_lookup = 17'd2427;
			15'd28: beta_lookup = 17'd2341;
			15'd29: beta_lookup = 17'd2260;
			15'd30: beta_lookup = 17'd2185;
			15'd31: beta_lookup = 17'd2114;
			15'd32: beta_lookup = 17'd2048;
			15'd33: beta_lookup = 17'd1986;
			default: beta_lookup = BETA_FLOOR;
		endcase
	endfunction

	function automatic logic [FSW_W-1:0] window_range(input logic [FRM_W-1:0] n);
		if (n < 15'd100) begin
			window_range = 9'd15;
		end else if (n < 15'd1000) begin
			window_range = 9'd50;
		end else if (n < 15'd10000) begin
			window_range = 9'd150;
		end else begin
			window_range = 9'd300;
		end
	endfunction

endpackage

FILE: rtl/core/mtne_ram.sv
module mtne_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/core/mtne_outq.sv
module mtne_outq (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	input  mtne_pkg::res_t                 push_item,
	output mtne_pkg::res_t                 head,
	output logic                           head_valid,
	input  logic                           head_ready,
	output logic [mtne_pkg::OQ_CW-1:0]     count
);

	mtne_pkg::res_t slots_q [mtne_pkg::OQ_DEPTH];
	logic [mtne_pkg::OQ_AW-1:0] wr_ptr_q;
	logic [mtne_pkg::OQ_AW-1:0] rd_ptr_q;
	logic [mtne_pkg::OQ_CW-1:0] cnt_q;
	logic pop;

	assign head_valid = cnt_q != '0;
	assign head       = slots_q[rd_ptr_q];
	assign pop        = head_valid & head_ready;
	assign count      = cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == mtne_pkg::OQ_AW'(mtne_pkg::OQ_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == mtne_pkg::OQ_AW'(mtne_pkg::OQ_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

FILE: rtl/core/minimum_tracking_noise_estimator.sv
// Channel    Dir  Signals                         Contents
// s_axis     in   tvalid tready tdata[39:0]       bin power, Q32.8
// m_axis     out  tvalid tready tdata tuser tlast index, smoothed power, noise
// apb        in   psel penable pwrite paddr ...   bins_per_frame at byte 0
//
// One bin transfer per cycle while s_axis_tready is high. Each bin does one
// read-modify-write of a 160-bit per-bin entry in a single RAM: read at issue,
// three compute stages (divide-by-20 chunks and the noise products), write back
// in the third, which also queues the result. The last bin of a frame
// issues two updates on consecutive cycles, overlapped with the next frame's
// first bin, which issues none. Entries not yet written since reset read as
// their reset value by a fill count; no clearing pass. s_axis_tready drops only
// when the 8-entry result queue cannot take two more results.
module minimum_tracking_noise_estimator (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [mtne_pkg::PWR_W-1:0]          s_axis_tdata,   // [39:0] bin_power
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// [9:0] bin_index, [49:10] smoothed_power, [89:50] noise_power, [95:90] zero
	output logic [mtne_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	output logic [0:0]                          m_axis_tuser,   // [0] noise_updated
	output logic                                m_axis_tlast,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [mtne_pkg::CFG_AW-1:0]         paddr,
	input  logic [mtne_pkg::CFG_DW-1:0]         pwdata,
	output logic [mtne_pkg::CFG_DW-1:0]         prdata,
	output logic                                pready
);

	logic [mtne_pkg::IDX_W-1:0] bins_q;
	logic [mtne_pkg::IDX_W-1:0] n_act;
	logic [mtne_pkg::IDX_W-1:0] pos_q;
	logic [mtne_pkg::IDX_W-1:0] fill_q;
	logic [mtne_pkg::FRM_W-1:0] frames_q;
	logic [mtne_pkg::FRM_W-1:0] fs_next;
	logic [mtne_pkg::FSW_W-1:0] fsw_q;
	logic [mtne_pkg::FSW_W-1:0] fsw_inc;
	logic [mtne_pkg::FSW_W-1:0] fsw_next;
	logic [mtne_pkg::PWR_W-1:0] prior0_q;
	logic [mtne_pkg::PWR_W-1:0] prior1_q;
	logic cfg_wr, in_acc, pos_first, is_last, issue_v, ent_ok;

	mtne_pkg::op_t in_op, tail_op, pend_q, iss_op;
	logic pend_v_q;

	logic [mtne_pkg::ENTRY_W-1:0] rd_data;
	logic [mtne_pkg::ENTRY_W-1:0] wr_data;
	logic [mtne_pkg::ADDR_W-1:0]  rd_addr;
	logic [mtne_pkg::ADDR_W-1:0]  wr_addr;

	// stage 1
	mtne_pkg::op_t op_s1;
	logic v_s1, ok_s1;
	mtne_pkg::entry_t ent_s1;
	logic [mtne_pkg::X_W-1:0]    x_s1;
	logic [mtne_pkg::QH_PW-1:0]  qh_prod_s1;
	logic [mtne_pkg::BETA_W-1:0] omb_s1;
	logic [mtne_pkg::NP_W-1:0]   np1_s1;
	logic [mtne_pkg::NP_W-1:0]   np2_s1;

	// stage 2
	mtne_pkg::op_t op_s2;
	logic v_s2;
	logic [mtne_pkg::QH_W-1:0]   qh_s2;
	logic [mtne_pkg::YH_W-1:0]   yh_s2;
	logic [mtne_pkg::DIV_LO-1:0] ylo_s2;
	logic [mtne_pkg::PWR_W-1:0]  rmin_s2;
	logic [mtne_pkg::PWR_W-1:0]  wmin_s2;
	logic [mtne_pkg::PWR_W-1:0]  nz_s2;
	logic [mtne_pkg::NP_W-1:0]   np1_s2;
	logic [mtne_pkg::NP_W-1:0]   np2_s2;
	logic [mtne_pkg::YH_W-1:0]   rem_s2;
	logic [mtne_pkg::Z_W-1:0]    z_s2;
	logic [mtne_pkg::QL_PW-1:0]  ql_prod_s2;
	logic [mtne_pkg::QH_W+mtne_pkg::DIV_LO-1:0] sfull_s2;
	logic [mtne_pkg::NSUM_W-1:0] nsum_s2;

	// stage 3
	mtne_pkg::op_t op_s3;
	logic v_s3;
	logic [mtne_pkg::PWR_W-1:0] s_s3;
	logic [mtne_pkg::PWR_W-1:0] nzn_s3;
	logic [mtne_pkg::PWR_W-1:0] rmin_s3;
	logic [mtne_pkg::PWR_W-1:0] wmin_s3;
	logic [mtne_pkg::PWR_W-1:0] nz_s3;
	logic [mtne_pkg::PWR_W-1:0] smin_s3;
	logic [mtne_pkg::PWR_W-1:0] stmp_s3;
	logic [mtne_pkg::PWR_W-1:0] nzo_s3;
	logic upd_s3;
	mtne_pkg::entry_t wb_ent;
	mtne_pkg::res_t res_s3;

	// last write, for a read that raced it
	logic wb_v_q;
	logic [mtne_pkg::IDX_W-1:0] wb_k_q;
	mtne_pkg::entry_t wb_ent_q;

	mtne_pkg::res_t head;
	logic [mtne_pkg::OQ_CW-1:0] oq_cnt;
	logic [mtne_pkg::OQ_CW:0]   reserved;

	// ---------------- configuration ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready &
		(paddr[mtne_pkg::CFG_AW-1:2] == mtne_pkg::REG_BINS_PER_FRAME);
	assign prdata = (paddr[mtne_pkg::CFG_AW-1:2] == mtne_pkg::REG_BINS_PER_FRAME) ?
		mtne_pkg::CFG_DW'(bins_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bins_q <= mtne_pkg::BINS_RESET;
		end else if (cfg_wr) begin
			bins_q <= pwdata[mtne_pkg::IDX_W-1:0];
		end
	end

	assign n_act = (bins_q < mtne_pkg::BINS_MIN) ? mtne_pkg::BINS_MIN :
		((bins_q > mtne_pkg::BINS_MAX) ? mtne_pkg::BINS_MAX : bins_q);

	// ---------------- input and frame tracking ----------------
	assign reserved = (mtne_pkg::OQ_CW + 1)'(oq_cnt) + (mtne_pkg::OQ_CW + 1)'(pend_v_q) +
		(mtne_pkg::OQ_CW + 1)'(v_s1) + (mtne_pkg::OQ_CW + 1)'(v_s2) +
		(mtne_pkg::OQ_CW + 1)'(v_s3);
	assign s_axis_tready = reserved <= (mtne_pkg::OQ_CW + 1)'(mtne_pkg::OQ_DEPTH - 2);
	assign in_acc    = s_axis_tvalid & s_axis_tready;
	assign pos_first = pos_q == '0;
	assign is_last   = ({1'b0, pos_q} + 1'b1) >= {1'b0, n_act};

	assign fs_next  = (frames_q >= mtne_pkg::FRAMES_CAP) ? mtne_pkg::FRAMES_CAP :
		frames_q + 1'b1;
	assign fsw_inc  = fsw_q + 1'b1;
	assign fsw_next = (fsw_inc > mtne_pkg::window_range(fs_next)) ? '0 : fsw_inc;

	always_comb begin
		in_op         = '0;
		in_op.k       = pos_q - 1'b1;
		in_op.pw      = prior1_q;
		if (pos_q == mtne_pkg::IDX_W'(1)) begin
			in_op.wsum = {prior1_q, 2'b00};
		end else begin
			in_op.wsum = mtne_pkg::WSUM_W'(prior0_q) + mtne_pkg::WSUM_W'({prior1_q, 1'b0}) +
				mtne_pkg::WSUM_W'(s_axis_tdata);
		end
		tail_op       = '0;
		tail_op.k     = pos_q;
		tail_op.wsum  = {s_axis_tdata, 2'b00};
		tail_op.pw    = s_axis_tdata;
		tail_op.last  = 1'b1;
	end

	// the deferred last-bin update and a first bin never issue together
	assign issue_v = pend_v_q | (in_acc & ~pos_first);

	always_comb begin
		iss_op         = pend_v_q ? pend_q : in_op;
		iss_op.first   = frames_q == mtne_pkg::FRM_W'(1);
		iss_op.restart = fsw_q == '0;
		iss_op.beta    = mtne_pkg::beta_lookup(frames_q);
	end

	assign rd_addr = iss_op.k[mtne_pkg::ADDR_W-1:0];
	assign ent_ok  = iss_op.k < fill_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			frames_q <= '0;
			fsw_q    <= '0;
			pend_v_q <= 1'b0;
			fill_q   <= '0;
		end else begin
			if (in_acc) begin
				if (pos_first) begin
					frames_q <= fs_next;
					fsw_q    <= fsw_next;
					pos_q    <= mtne_pkg::IDX_W'(1);
				end else begin
					pos_q <= is_last ? '0 : pos_q + 1'b1;
				end
			end
			pend_v_q <= in_acc & ~pos_first & is_last;
			// entries are first touched in index order, so a count marks the written prefix
			if (issue_v && (iss_op.k >= fill_q)) begin
				fill_q <= iss_op.k + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			if (pos_first) begin
				prior0_q <= '0;
			end else begin
				prior0_q <= prior1_q;
			end
			prior1_q <= s_axis_tdata;
			pend_q   <= tail_op;
		end
	end

	// ---------------- state memory ----------------
	mtne_ram #(
		.WIDTH(mtne_pkg::ENTRY_W),
		.DEPTH(mtne_pkg::MAX_BINS)
	) u_state_ram (
		.clk  (clk),
		.we   (v_s3),
		.waddr(wr_addr),
		.wdata(wr_data),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	// ---------------- stage 1: entry select, first divide chunk, noise products -------
	always_comb begin
		if (wb_v_q && (wb_k_q == op_s1.k)) begin
			ent_s1 = wb_ent_q;
		end else if (ok_s1) begin
			ent_s1 = mtne_pkg::entry_t'(rd_data);
		end else begin
			ent_s1 = mtne_pkg::ENTRY_INIT;
		end
		x_s1 = mtne_pkg::X_W'({ent_s1.smooth, 4'b0000}) + mtne_pkg::X_W'(op_s1.wsum) +
			mtne_pkg::X_W'(10);
		qh_prod_s1 = mtne_pkg::QH_PW'(x_s1[mtne_pkg::X_W-1:mtne_pkg::DIV_LO+2]) *
			mtne_pkg::QH_PW'(mtne_pkg::DIV5_M);
		omb_s1 = mtne_pkg::BETA_ONE - op_s1.beta;
		np1_s1 = mtne_pkg::NP_W'(omb_s1) * mtne_pkg::NP_W'(ent_s1.noise);
		np2_s1 = mtne_pkg::NP_W'(op_s1.beta) * mtne_pkg::NP_W'(op_s1.pw);
	end

	always_ff @(posedge clk) begin
		op_s1  <= iss_op;
		ok_s1  <= ent_ok;
		op_s2  <= op_s1;
		qh_s2  <= qh_prod_s1[mtne_pkg::DIV_SH+mtne_pkg::QH_W-1:mtne_pkg::DIV_SH];
		yh_s2  <= x_s1[mtne_pkg::X_W-1:mtne_pkg::DIV_LO+2];
		ylo_s2 <= x_s1[mtne_pkg::DIV_LO+1:2];
		// minima read as zero throughout the first frame
		rmin_s2 <= op_s1.first ? '0 : ent_s1.rmin;
		wmin_s2 <= op_s1.first ? '0 : ent_s1.wmin;
		nz_s2   <= ent_s1.noise;
		np1_s2  <= np1_s1;
		np2_s2  <= np2_s1;
	end

	// ---------------- stage 2: second divide chunk, noise sum ----------------
	always_comb begin
		rem_s2 = yh_s2 - (mtne_pkg::YH_W'({qh_s2, 2'b00}) + mtne_pkg::YH_W'(qh_s2));
		z_s2   = {rem_s2[2:0], ylo_s2};
		ql_prod_s2 = mtne_pkg::QL_PW'(z_s2) * mtne_pkg::QL_PW'(mtne_pkg::DIV5_M);
		sfull_s2 = {qh_s2,
			ql_prod_s2[mtne_pkg::DIV_SH+mtne_pkg::DIV_LO-1:mtne_pkg::DIV_SH]};
		nsum_s2 = mtne_pkg::NSUM_W'(np1_s2) + mtne_pkg::NSUM_W'(np2_s2) + mtne_pkg::NZ_ROUND;
	end

	always_ff @(posedge clk) begin
		op_s3   <= op_s2;
		s_s3    <= sfull_s2[mtne_pkg::PWR_W-1:0];
		nzn_s3  <= nsum_s2[mtne_pkg::PWR_W+15:16];
		rmin_s3 <= rmin_s2;
		wmin_s3 <= wmin_s2;
		nz_s3   <= nz_s2;
	end

	// ---------------- stage 3: minima, decision, write back ----------------
	always_comb begin
		if (op_s3.restart) begin
			smin_s3 = (wmin_s3 < s_s3) ? wmin_s3 : s_s3;
			stmp_s3 = s_s3;
		end else begin
			smin_s3 = (s_s3 < rmin_s3) ? s_s3 : rmin_s3;
			stmp_s3 = (s_s3 < wmin_s3) ? s_s3 : wmin_s3;
		end
		upd_s3 = ((mtne_pkg::PWR_W + 3)'({s_s3, 1'b0}) <
			((mtne_pkg::PWR_W + 3)'({smin_s3, 2'b00}) + (mtne_pkg::PWR_W + 3)'(smin_s3))) ||
			(op_s3.pw < nz_s3);
		nzo_s3 = upd_s3 ? nzn_s3 : nz_s3;

		wb_ent.smooth = s_s3;
		wb_ent.rmin   = smin_s3;
		wb_ent.wmin   = stmp_s3;
		wb_ent.noise  = nzo_s3;

		res_s3.idx    = op_s3.k;
		res_s3.smooth = s_s3;
		res_s3.noise  = nzo_s3;
		res_s3.upd    = upd_s3;
		res_s3.last   = op_s3.last;
	end

	assign wr_addr = op_s3.k[mtne_pkg::ADDR_W-1:0];
	assign wr_data = wb_ent;

	always_ff @(posedge clk) begin
		wb_k_q   <= op_s3.k;
		wb_ent_q <= wb_ent;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			wb_v_q <= 1'b0;
		end else begin
			v_s1   <= issue_v;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			wb_v_q <= v_s3;
		end
	end

	// ---------------- result queue ----------------
	mtne_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (v_s3),
		.push_item (res_s3),
		.head      (head),
		.head_valid(m_axis_tvalid),
		.head_ready(m_axis_tready),
		.count     (oq_cnt)
	);

	assign m_axis_tdata = {{mtne_pkg::OUT_PAD_W{1'b0}}, head.noise, head.smooth, head.idx};
	assign m_axis_tuser = head.upd;
	assign m_axis_tlast = head.last;

endmodule
